FILE: hw/rtl/vgcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgcm_pkg
// Shared widths, constants, operation codes and the controller command
// bundle of the visited grid coverage map.
// ----------------------------------------------------------------------------
package vgcm_pkg;

   localparam int MAX_SIDE  = 64;
   localparam int CELL_SIZE = 1000;
   localparam int HALF_MAX  = MAX_SIDE / 2;

   localparam int POS_W    = 24;
   localparam int CIDX_W   = 8;
   localparam int IDX_W    = 6;
   localparam int HALF_W   = 6;
   localparam int CENTRE_W = 16;
   localparam int COUNT_W  = 13;
   localparam int OP_W     = 2;

   // reciprocal division by the cell size; exact below SAT_LIMIT
   localparam int SAT_LIMIT    = MAX_SIDE * CELL_SIZE;
   localparam int RECIP_SHIFT  = 26;
   localparam int RECIP_MULT   = (2 ** RECIP_SHIFT + CELL_SIZE - 1) / CELL_SIZE;
   localparam int DIV_IN_W     = 16;
   localparam int RECIP_W      = 17;
   localparam int QUOT_W       = 7;

   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(8);

   localparam logic [OP_W-1:0] OP_MARK       = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY_POS  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY_CELL = 2'd2;

   typedef struct packed {
      logic load;     // transfer accepted: capture request fields
      logic calc;     // index calculation and row read
      logic update;   // row write-back, count and response capture
   } vgcm_cmd_type;

endpackage
`default_nettype wire

FILE: hw/rtl/vgcm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgcm_ctrl
// Sequencer: accepts requests, steps the datapath through index
// calculation and row update, and raises the response strobe.
// ----------------------------------------------------------------------------
module vgcm_ctrl
   import vgcm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output logic              rsp_strobe,
   output vgcm_cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_CALC;
         S_CALC:   state_in = S_UPDATE;
         S_UPDATE: state_in = accept ? S_CALC : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in == S_CALC);
         strobe_ff <= (state_ff == S_UPDATE);
      end
   end

   assign cmd.load   = accept;
   assign cmd.calc   = (state_ff == S_CALC);
   assign cmd.update = (state_ff == S_UPDATE);
   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/vgcm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgcm_datapath
// Grid size register, position-to-cell mapping, bitmap row memory with
// per-row valid bits, set-cell count and response registers.
// ----------------------------------------------------------------------------
module vgcm_datapath
   import vgcm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire vgcm_cmd_type               cmd,
   input  wire logic                       csr_wr_en,
   input  wire logic [HALF_W-1:0]          csr_wr_data,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic signed [POS_W-1:0]    req_pos_x,
   input  wire logic signed [POS_W-1:0]    req_pos_y,
   input  wire logic signed [CIDX_W-1:0]   req_cell_col_in,
   input  wire logic signed [CIDX_W-1:0]   req_cell_row_in,
   output logic                            rsp_covered,
   output logic                            rsp_in_area,
   output logic [IDX_W-1:0]                rsp_cell_col,
   output logic [IDX_W-1:0]                rsp_cell_row,
   output logic signed [CENTRE_W-1:0]      rsp_center_x,
   output logic signed [CENTRE_W-1:0]      rsp_center_y,
   output logic [COUNT_W-1:0]              rsp_covered_count
);

   localparam int SIDX_W = CIDX_W + 1;
   localparam int PROD_W = DIV_IN_W + RECIP_W;
   localparam int CFULL_W = CENTRE_W + 2;

   // offset of a coordinate from the grid centre, saturated to +-MAX_SIDE
   function automatic logic signed [CIDX_W-1:0] cell_offset(
      input logic signed [POS_W-1:0] v
   );
      logic [POS_W:0]        mag;
      logic [PROD_W-1:0]     prod;
      logic [QUOT_W-1:0]     q;
      logic signed [CIDX_W-1:0] qs;
      mag  = v[POS_W-1] ? ((POS_W+1)'(CELL_SIZE) - {v[POS_W-1], v}) : {1'b0, v};
      prod = {{RECIP_W{1'b0}}, mag[DIV_IN_W-1:0]} * PROD_W'(RECIP_MULT);
      q    = (mag >= (POS_W+1)'(SAT_LIMIT)) ? QUOT_W'(MAX_SIDE)
                                            : prod[RECIP_SHIFT +: QUOT_W];
      qs   = $signed({1'b0, q});
      return v[POS_W-1] ? -qs : qs;
   endfunction

   // clamp a signed index into [0, side-1]
   function automatic logic [IDX_W-1:0] clamp_idx(
      input logic signed [SIDX_W-1:0] i,
      input logic signed [SIDX_W-1:0] side
   );
      logic signed [SIDX_W-1:0] last;
      last = side - SIDX_W'(1);
      if (i < 0)
         return '0;
      else if (i > last)
         return last[IDX_W-1:0];
      else
         return i[IDX_W-1:0];
   endfunction

   // grid size register
   logic [HALF_W-1:0] half_ff;
   logic [HALF_W-1:0] h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_RESET;
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (half_ff == '0)
         h_eff = HALF_W'(1);
      else if (half_ff > HALF_W'(HALF_MAX))
         h_eff = HALF_W'(HALF_MAX);
      else
         h_eff = half_ff;
   end

   // request capture
   logic [OP_W-1:0]          op_ff;
   logic signed [POS_W-1:0]  pos_x_ff, pos_y_ff;
   logic signed [CIDX_W-1:0] col_in_ff, row_in_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         pos_x_ff  <= req_pos_x;
         pos_y_ff  <= req_pos_y;
         col_in_ff <= req_cell_col_in;
         row_in_ff <= req_cell_row_in;
      end
   end

   // index calculation
   logic signed [SIDX_W-1:0] col_s, row_s, side_s, h_s;
   logic signed [CIDX_W-1:0] off_x, off_y;
   logic                     in_grid;
   logic [IDX_W-1:0]         ccol, crow;

   always_comb begin
      h_s    = $signed({3'b000, h_eff});
      side_s = $signed({2'b00, h_eff, 1'b0});
      off_x  = cell_offset(pos_x_ff);
      off_y  = cell_offset(pos_y_ff);
      if (op_ff == OP_QUERY_CELL) begin
         col_s = {col_in_ff[CIDX_W-1], col_in_ff};
         row_s = {row_in_ff[CIDX_W-1], row_in_ff};
      end else begin
         col_s = h_s + {off_x[CIDX_W-1], off_x};
         row_s = h_s + {off_y[CIDX_W-1], off_y};
      end
      in_grid = (col_s >= 0) && (col_s < side_s) && (row_s >= 0) && (row_s < side_s);
      ccol    = clamp_idx(col_s, side_s);
      crow    = clamp_idx(row_s, side_s);
   end

   logic [IDX_W-1:0] ccol_ff, crow_ff;
   logic             in_grid_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         ccol_ff    <= ccol;
         crow_ff    <= crow;
         in_grid_ff <= in_grid;
      end
   end

   // bitmap: one row of cells per word
   logic [MAX_SIDE-1:0] map_mem [0:MAX_SIDE-1];
   logic [MAX_SIDE-1:0] rd_word_ff;
   logic [MAX_SIDE-1:0] row_valid_ff;
   logic [MAX_SIDE-1:0] word, new_word;
   logic                old_bit, do_mark;

   assign do_mark  = cmd.update && (op_ff == OP_MARK);
   assign word     = row_valid_ff[crow_ff] ? rd_word_ff : '0;
   assign old_bit  = word[ccol_ff];
   assign new_word = word | (MAX_SIDE'(1) << ccol_ff);

   always_ff @(posedge clock) begin
      if (do_mark)
         map_mem[crow_ff] <= new_word;
      if (cmd.calc)
         rd_word_ff <= map_mem[crow];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (do_mark) begin
         row_valid_ff[crow_ff] <= 1'b1;
      end
   end

   // count and response
   logic [COUNT_W-1:0] count_ff, count_in;

   assign count_in = (do_mark && !old_bit) ? count_ff + COUNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   logic signed [CIDX_W-1:0]  dcol, drow;
   logic signed [CFULL_W-1:0] cx_full, cy_full;
   logic                      cov;

   always_comb begin
      dcol    = $signed({2'b00, ccol_ff}) - $signed({2'b00, h_eff});
      drow    = $signed({2'b00, crow_ff}) - $signed({2'b00, h_eff});
      cx_full = $signed({{(CFULL_W-CIDX_W){dcol[CIDX_W-1]}}, dcol}) * CFULL_W'(CELL_SIZE)
                + CFULL_W'(CELL_SIZE / 2);
      cy_full = $signed({{(CFULL_W-CIDX_W){drow[CIDX_W-1]}}, drow}) * CFULL_W'(CELL_SIZE)
                + CFULL_W'(CELL_SIZE / 2);
      if (op_ff == OP_MARK)
         cov = 1'b1;
      else if (op_ff == OP_QUERY_CELL && !in_grid_ff)
         cov = 1'b0;
      else
         cov = old_bit;
   end

   logic                       covered_ff, in_area_ff;
   logic [IDX_W-1:0]           cell_col_ff, cell_row_ff;
   logic signed [CENTRE_W-1:0] center_x_ff, center_y_ff;
   logic [COUNT_W-1:0]         rsp_count_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         covered_ff   <= cov;
         in_area_ff   <= in_grid_ff;
         cell_col_ff  <= ccol_ff;
         cell_row_ff  <= crow_ff;
         center_x_ff  <= cx_full[CENTRE_W-1:0];
         center_y_ff  <= cy_full[CENTRE_W-1:0];
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_covered       = covered_ff;
   assign rsp_in_area       = in_area_ff;
   assign rsp_cell_col      = cell_col_ff;
   assign rsp_cell_row      = cell_row_ff;
   assign rsp_center_x      = center_x_ff;
   assign rsp_center_y      = center_y_ff;
   assign rsp_covered_count = rsp_count_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/visited_grid_coverage_map_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// visited_grid_coverage_map_unit
// Bitmap of visited grid cells with mark, position query and cell query.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Request: drive req_* and raise start; a transfer happens at a rising
//    edge with start high and busy low. req_operation: mark position,
//    query position or query cell by index (code 3 acts as a position query).
//  - Response: rsp_* fields are valid for exactly one cycle, flagged by
//    rsp_strobe. The receiver cannot stall; every transfer gives one response.
//  - Sequence: request captured at the accepting edge, cell index and row
//    word registered in the calculation cycle, response and strobe in the
//    update cycle. busy is high during the calculation cycle of each transfer;
//    the bitmap row is read in that cycle and written back in the next, so
//    a new request can be taken during the previous one's update cycle.
//  - Config: csr_wr_en/csr_wr_data write the grid half side (cells); only
//    while no request is in flight. Reset value 8, saturated into 1..32.
//  - Reset (synchronous): the map reads as empty at once via per-row valid
//    bits (no clearing sweep), count is zero, no response pending.
// ----------------------------------------------------------------------------
module visited_grid_coverage_map_unit
   import vgcm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [OP_W-1:0]            req_operation,
   input  wire logic signed [POS_W-1:0]    req_pos_x,
   input  wire logic signed [POS_W-1:0]    req_pos_y,
   input  wire logic signed [CIDX_W-1:0]   req_cell_col_in,
   input  wire logic signed [CIDX_W-1:0]   req_cell_row_in,
   output logic                            rsp_strobe,
   output logic                            rsp_covered,
   output logic                            rsp_in_area,
   output logic [IDX_W-1:0]                rsp_cell_col,
   output logic [IDX_W-1:0]                rsp_cell_row,
   output logic signed [CENTRE_W-1:0]      rsp_center_x,
   output logic signed [CENTRE_W-1:0]      rsp_center_y,
   output logic [COUNT_W-1:0]              rsp_covered_count,
   input  wire logic                       csr_wr_en,
   input  wire logic [HALF_W-1:0]          csr_wr_data
);

   vgcm_cmd_type cmd;

   // sequencer: transfer, calculation cycle, update cycle
   vgcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // mapping, bitmap memory, count and response registers
   vgcm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_operation     (req_operation),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_cell_col_in   (req_cell_col_in),
      .req_cell_row_in   (req_cell_row_in),
      .rsp_covered       (rsp_covered),
      .rsp_in_area       (rsp_in_area),
      .rsp_cell_col      (rsp_cell_col),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_center_x      (rsp_center_x),
      .rsp_center_y      (rsp_center_y),
      .rsp_covered_count (rsp_covered_count)
   );

   // busy always drops in the cycle after the calculation cycle
   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy) else $error("busy held longer than one cycle");

   // each transfer enters the calculation cycle next
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer did not start calculation");

   // a response is preceded by a calculation cycle, with the update cycle between
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy, 2)) else $error("response without a request");

   // the count never exceeds the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_covered_count <= COUNT_W'(MAX_SIDE * MAX_SIDE)))
      else $error("set-cell count out of range");

endmodule
`default_nettype wire

FILE: tb/sv/tb_visited_grid_coverage_map_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_visited_grid_coverage_map_unit
// Self-checking bench for the visited grid coverage map. A shadow bitmap,
// count and half-side register predict every response. Directed items cover
// cell borders, coordinate extremes, out-of-range cell queries and the
// half-side limits. Random traffic follows wandering tracks over several grid
// sizes, with random gaps between requests in most phases and none in others.
// ----------------------------------------------------------------------------
module tb_visited_grid_coverage_map_unit
   import vgcm_pkg::*;
();

   // code 3 has no package name; the block treats it as a position query
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam int MAX_GAP       = 10;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_ITEMS  = 800;
   localparam int RANDOM_PHASES = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic                       covered;
      logic                       in_area;
      logic [IDX_W-1:0]           cell_col;
      logic [IDX_W-1:0]           cell_row;
      logic signed [CENTRE_W-1:0] center_x;
      logic signed [CENTRE_W-1:0] center_y;
      logic [COUNT_W-1:0]         covered_count;
   } cell_report_type;

   // ------------------------------------------------------------------------
   // Block ports; the inputs are known from time zero
   // ------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [OP_W-1:0]            req_operation = OP_QUERY_POS;
   logic signed [POS_W-1:0]    req_pos_x = '0;
   logic signed [POS_W-1:0]    req_pos_y = '0;
   logic signed [CIDX_W-1:0]   req_cell_col_in = '0;
   logic signed [CIDX_W-1:0]   req_cell_row_in = '0;
   logic                       rsp_strobe;
   logic                       rsp_covered;
   logic                       rsp_in_area;
   logic [IDX_W-1:0]           rsp_cell_col;
   logic [IDX_W-1:0]           rsp_cell_row;
   logic signed [CENTRE_W-1:0] rsp_center_x;
   logic signed [CENTRE_W-1:0] rsp_center_y;
   logic [COUNT_W-1:0]         rsp_covered_count;
   logic                       csr_wr_en = 1'b0;
   logic [HALF_W-1:0]          csr_wr_data = '0;

   // ------------------------------------------------------------------------
   // Shadow state of the map and the queue of responses still owed
   // ------------------------------------------------------------------------
   bit                 shadow_map [MAX_SIDE*MAX_SIDE];
   logic [COUNT_W-1:0] shadow_count = '0;
   logic [HALF_W-1:0]  shadow_half = HALF_RESET;
   cell_report_type    cell_reports_due [$];

   int mismatches   = 0;
   bit back_to_back = 1'b0;   // when set, requests follow with no gap

   visited_grid_coverage_map_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_cell_col_in   (req_cell_col_in),
      .req_cell_row_in   (req_cell_row_in),
      .rsp_strobe        (rsp_strobe),
      .rsp_covered       (rsp_covered),
      .rsp_in_area       (rsp_in_area),
      .rsp_cell_col      (rsp_cell_col),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_center_x      (rsp_center_x),
      .rsp_center_y      (rsp_center_y),
      .rsp_covered_count (rsp_covered_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   // register value saturated into 1..HALF_MAX
   function automatic longint effective_half();
      longint h;
      h = longint'(shadow_half);
      if (h < 1) h = 1;
      if (h > HALF_MAX) h = HALF_MAX;
      return h;
   endfunction

   // cells from the centre: floor(v/size) when v >= 0, floor((v-1)/size) below
   function automatic longint cell_offset(longint v);
      if (v >= 0) return v / CELL_SIZE;
      return -((CELL_SIZE - v) / CELL_SIZE);
   endfunction

   function automatic longint clamp_index(longint i, longint side);
      if (i > side - 1) i = side - 1;
      if (i < 0) i = 0;
      return i;
   endfunction

   // works out one response and applies a mark to the shadow map
   function automatic cell_report_type compute_cell_report(
      logic [OP_W-1:0] op, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
      logic signed [CIDX_W-1:0] c, logic signed [CIDX_W-1:0] r);
      longint          h, side, col, row, ccol, crow;
      int              addr;
      bit              in_grid;
      cell_report_type rep;
      h    = effective_half();
      side = 2 * h;
      if (op == OP_QUERY_CELL) begin
         col = longint'(c);
         row = longint'(r);
      end else begin
         col = h + cell_offset(longint'(x));
         row = h + cell_offset(longint'(y));
      end
      // in-area judged before clamping
      in_grid = (col >= 0) && (col < side) && (row >= 0) && (row < side);
      ccol    = clamp_index(col, side);
      crow    = clamp_index(row, side);
      addr    = int'(crow * MAX_SIDE + ccol);
      if (op == OP_MARK && !shadow_map[addr]) begin
         shadow_map[addr] = 1'b1;
         shadow_count     = shadow_count + 1'b1;
      end
      // a cell query outside the grid never reports a set bit
      rep.covered       = (op == OP_QUERY_CELL && !in_grid) ? 1'b0 : shadow_map[addr];
      rep.in_area       = in_grid;
      rep.cell_col      = IDX_W'(ccol);
      rep.cell_row      = IDX_W'(crow);
      rep.center_x      = CENTRE_W'((ccol - h) * CELL_SIZE + CELL_SIZE / 2);
      rep.center_y      = CENTRE_W'((crow - h) * CELL_SIZE + CELL_SIZE / 2);
      rep.covered_count = shadow_count;
      return rep;
   endfunction

   // ------------------------------------------------------------------------
   // Response checking: every strobe is matched against the oldest entry
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      cell_report_type due;
      if (!reset && rsp_strobe) begin
         if (cell_reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response with nothing outstanding", $realtime);
         end else begin
            due = cell_reports_due.pop_front();
            check_field("covered", due.covered, rsp_covered);
            check_field("in_area", due.in_area, rsp_in_area);
            check_field("cell_col", due.cell_col, rsp_cell_col);
            check_field("cell_row", due.cell_row, rsp_cell_row);
            check_field("center_x", due.center_x, rsp_center_x);
            check_field("center_y", due.center_y, rsp_center_y);
            check_field("covered_count", due.covered_count, rsp_covered_count);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driving. Always entered just after a rising edge. start is left
   // high after a transfer, so a follow-on request with no gap never lowers
   // and raises it in the same step.
   // ------------------------------------------------------------------------
   task automatic send_item(logic [OP_W-1:0] op, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [CIDX_W-1:0] c,
                            logic signed [CIDX_W-1:0] r);
      int              gap;
      cell_report_type rep;
      gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_cell_col_in <= c;
      req_cell_row_in <= r;
      // transfer at the first edge that sees busy low
      do @(posedge clock); while (busy);
      rep              = compute_cell_report(op, x, y, c, r);
      cell_reports_due = {cell_reports_due, rep};
   endtask

   // half-side write, only once every response is in
   task automatic set_half_side(logic [HALF_W-1:0] value);
      start <= 1'b0;
      while (cell_reports_due.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_half  = value;
   endtask

   // ------------------------------------------------------------------------
   // Random field generators
   // ------------------------------------------------------------------------
   function automatic logic signed [POS_W-1:0] rand_coord(longint h);
      longint reach, k;
      int     pick;
      pick  = $urandom_range(0, 9);
      reach = (h + 2) * CELL_SIZE;
      if (pick < 6) return POS_W'(longint'($urandom_range(0, 2 * reach)) - reach);
      if (pick < 8) begin
         // just either side of a cell border
         k = longint'($urandom_range(0, 2 * h + 2)) - h - 1;
         return POS_W'(k * CELL_SIZE + longint'($urandom_range(0, 2)) - 1);
      end
      return POS_W'($urandom);
   endfunction

   function automatic logic signed [CIDX_W-1:0] rand_index(longint h);
      if ($urandom_range(0, 4) == 0) return CIDX_W'(int'($urandom_range(0, 191)) - 64);
      return CIDX_W'(longint'($urandom_range(0, 2 * h + 3)) - 2);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // empty map straight after reset, default half side of eight
   task automatic test_reset_state();
      send_item(OP_QUERY_POS, 0, 0, 0, 0);
      send_item(OP_QUERY_CELL, 0, 0, 127, -64);
   endtask

   // cell borders around zero, grid edges and the coordinate extremes
   task automatic test_coordinate_edges();
      send_item(OP_MARK, 0, -1, 0, 0);
      send_item(OP_MARK, 999, -1000, 0, 0);
      send_item(OP_MARK, 1000, -1001, 0, 0);
      send_item(OP_MARK, 7999, -7000, 0, 0);
      send_item(OP_MARK, 8000, -8000, 0, 0);
      send_item(OP_MARK, 8388607, -8388608, 0, 0);
      send_item(OP_QUERY_POS, -8388608, 8388607, 0, 0);
      send_item(OP_QUERY_POS, 999, -1, 0, 0);
      send_item(OP_SPARE, 1000, -1001, 0, 0);
   endtask

   // cell queries inside, at the edges and out of range on both sides
   task automatic test_cell_queries();
      send_item(OP_QUERY_CELL, 0, 0, 8, 7);
      send_item(OP_QUERY_CELL, 0, 0, 15, 0);
      send_item(OP_QUERY_CELL, 0, 0, 16, 15);
      send_item(OP_QUERY_CELL, 0, 0, -1, -64);
      send_item(OP_QUERY_CELL, 0, 0, 127, 127);
   endtask

   // half side zero, above the limit, at the limit and minimum; bits survive
   task automatic test_half_side_extremes();
      set_half_side(0);
      send_item(OP_MARK, -1, -1, 0, 0);
      send_item(OP_QUERY_CELL, 0, 0, 2, 1);
      set_half_side(63);
      send_item(OP_MARK, 31999, -32001, 0, 0);
      send_item(OP_QUERY_CELL, 0, 0, 63, 0);
      set_half_side(HALF_MAX);
      send_item(OP_QUERY_CELL, 0, 0, 0, 0);
      set_half_side(1);
      send_item(OP_MARK, 5000, 5000, 0, 0);
      send_item(OP_QUERY_CELL, 0, 0, 1, 1);
      set_half_side(HALF_RESET);
   endtask

   // wandering tracks with random content over several grid sizes
   task automatic test_random_traffic();
      int                       phase, n, pick;
      longint                   h, bound, walk_x, walk_y;
      logic [OP_W-1:0]          op;
      logic signed [POS_W-1:0]  x, y;
      logic signed [CIDX_W-1:0] c, r;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            1: set_half_side(1);
            2: set_half_side(HALF_MAX);
            3: set_half_side(0);
            4: set_half_side(63);
            5: set_half_side(2);
            default: set_half_side(HALF_W'($urandom_range(0, 63)));
         endcase
         h            = effective_half();
         bound        = (h + 3) * CELL_SIZE;
         back_to_back = (phase % 3 == 2);
         walk_x       = 0;
         walk_y       = 0;
         for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) op = OP_MARK;
            else if (pick < 70) op = OP_QUERY_POS;
            else if (pick < 95) op = OP_QUERY_CELL;
            else op = OP_SPARE;
            walk_x += longint'($urandom_range(0, 3000)) - 1500;
            walk_y += longint'($urandom_range(0, 3000)) - 1500;
            if (walk_x > bound) walk_x = bound;
            if (walk_x < -bound) walk_x = -bound;
            if (walk_y > bound) walk_y = bound;
            if (walk_y < -bound) walk_y = -bound;
            x = ($urandom_range(0, 9) < 6) ? POS_W'(walk_x) : rand_coord(h);
            y = ($urandom_range(0, 9) < 6) ? POS_W'(walk_y) : rand_coord(h);
            c = rand_index(h);
            r = rand_index(h);
            send_item(op, x, y, c, r);
         end
      end
      back_to_back = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_coordinate_edges();
      test_cell_queries();
      test_half_side_extremes();
      test_random_traffic();
      start <= 1'b0;
      while (cell_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** visited_grid_coverage_map_unit: PASSED **");
      else
         $display("** visited_grid_coverage_map_unit: FAILED **");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("** visited_grid_coverage_map_unit: FAILED **");
      $finish;
   end

endmodule
